// ----- rtl/core/msb_pkg.sv -----
// msb_pkg: shared types and constants of the merge sort buffer
// command and status structs between controller and datapath
// no dependencies
`default_nettype none

package msb_pkg;

    // width of one stored element
    localparam int DATA_W = 64;

    // controller to datapath commands
    typedef struct packed {
        logic load;         // input transaction accepted
        logic sort_init;    // width one, source is the element store
        logic pass_start;   // set up first run of a merge pass
        logic run_next;     // set up next run of the current pass
        logic merge_write;  // write one merged element
        logic pass_end;     // double width, swap source and destination
        logic out_start;    // rewind read pointer for output
        logic out_next;     // step read pointer after an output transaction
        logic clear;        // drop count and overflow after the run
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic k_last;       // write or read pointer is on the final element
        logic run_done;     // write pointer is on the final element of a run
        logic sort_done;    // merge width covers the whole run
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/core/msb_ram.sv -----
// msb_ram: generic simple dual-port ram, one write and two read ports
// read data is registered; no package dependency
`default_nettype none

module msb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

`default_nettype wire

// ----- rtl/core/msb_ctrl.sv -----
// msb_ctrl: sequencer of the merge sort buffer (load, merge passes, output)
// depends on msb_pkg for the command and status structs
`default_nettype none

module msb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_s_tlast,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output msb_pkg::t_cmd      o_cmd,
    input  wire msb_pkg::t_sts i_sts
);

    import msb_pkg::*;

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_SORT_INIT = 3'd1;
    localparam logic [2:0] ST_PASS_CHK  = 3'd2;
    localparam logic [2:0] ST_MRG_RD    = 3'd3;
    localparam logic [2:0] ST_MRG_WR    = 3'd4;
    localparam logic [2:0] ST_OUT_RD    = 3'd5;
    localparam logic [2:0] ST_OUT_VLD   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       s_acc;

    assign o_s_tready = (r_state == ST_LOAD);
    assign o_m_tvalid = (r_state == ST_OUT_VLD);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load = s_acc;
                if (s_acc && i_s_tlast) begin
                    n_state = ST_SORT_INIT;
                end
            end
            ST_SORT_INIT: begin
                o_cmd.sort_init = 1'b1;
                n_state         = ST_PASS_CHK;
            end
            ST_PASS_CHK: begin
                if (i_sts.sort_done) begin
                    o_cmd.out_start = 1'b1;
                    n_state         = ST_OUT_RD;
                end else begin
                    o_cmd.pass_start = 1'b1;
                    n_state          = ST_MRG_RD;
                end
            end
            ST_MRG_RD: begin
                // read data of both heads arrives next cycle
                n_state = ST_MRG_WR;
            end
            ST_MRG_WR: begin
                o_cmd.merge_write = 1'b1;
                n_state           = ST_MRG_RD;
                if (i_sts.k_last) begin
                    o_cmd.pass_end = 1'b1;
                    n_state        = ST_PASS_CHK;
                end else if (i_sts.run_done) begin
                    o_cmd.run_next = 1'b1;
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_VLD;
            end
            ST_OUT_VLD: begin
                if (i_m_tready) begin
                    if (i_sts.k_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // a final input item starts the sort
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_tlast |=> r_state == ST_SORT_INIT)
        else $error("last input did not start the sort");

    // the final output transaction reopens the input
    a_end_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && i_sts.k_last |=> o_s_tready)
        else $error("input not reopened after end of run");

    // never loading and emitting at once
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while output valid");

endmodule

`default_nettype wire

// ----- rtl/core/msb_dp.sv -----
// msb_dp: datapath of the merge sort buffer, two ping-pong stores,
// merge pointers, compare and the config bit; depends on msb_pkg and msb_ram
`default_nettype none

module msb_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire msb_pkg::t_cmd               i_cmd,
    output msb_pkg::t_sts                    o_sts,
    input  wire logic signed [msb_pkg::DATA_W-1:0] i_value,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_data,
    output logic                             o_cfg_ready,
    output logic signed [msb_pkg::DATA_W-1:0] o_sorted_value,
    output logic                             o_end_of_run,
    output logic                             o_overflow
);

    import msb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;

    logic [CW-1:0] r_count;
    logic          r_dropped;
    logic          r_desc;
    logic          r_src;      // 0: element store is source, 1: scratch store
    logic [WW-1:0] r_w;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_k;

    logic [DATA_W-1:0] rd_e0, rd_e1, rd_s0, rd_s1;
    logic [DATA_W-1:0] head_a, head_b, mrg_data;
    logic              keep, take_left, store_en;
    logic              e_we, s_we;
    logic [AW-1:0]     e_waddr;
    logic [DATA_W-1:0] e_wdata;
    logic [CW-1:0]     lo_sel, mid_new, hi_new;
    logic [SW-1:0]     lo_ext, w_ext, n_ext, mid_sum, hi_sum;

    // heads of the two runs from the current source
    assign head_a = r_src ? rd_s0 : rd_e0;
    assign head_b = r_src ? rd_s1 : rd_e1;

    // stable compare, ties favor the left run
    assign keep = r_desc ? ($signed(head_a) >= $signed(head_b))
                         : ($signed(head_a) <= $signed(head_b));
    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || keep);
    assign mrg_data  = take_left ? head_a : head_b;

    // bounds of the next run, clipped to the run length
    assign lo_sel  = i_cmd.pass_start ? '0 : r_hi;
    assign lo_ext  = SW'(lo_sel);
    assign w_ext   = SW'(r_w);
    assign n_ext   = SW'(r_count);
    assign mid_sum = lo_ext + w_ext;
    assign hi_sum  = lo_ext + (w_ext << 1);
    assign mid_new = (mid_sum > n_ext) ? r_count : mid_sum[CW-1:0];
    assign hi_new  = (hi_sum > n_ext) ? r_count : hi_sum[CW-1:0];

    // write port steering: loads go to the element store only
    assign store_en = i_cmd.load && (r_count < CW'(CAPACITY));
    assign e_we     = store_en || (i_cmd.merge_write && r_src);
    assign s_we     = i_cmd.merge_write && !r_src;
    assign e_waddr  = i_cmd.load ? r_count[AW-1:0] : r_k[AW-1:0];
    assign e_wdata  = i_cmd.load ? i_value : mrg_data;

    msb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_elem_ram (
        .i_clk    (i_clk),
        .i_we     (e_we),
        .i_waddr  (e_waddr),
        .i_wdata  (e_wdata),
        .i_raddr0 (r_i[AW-1:0]),
        .i_raddr1 (r_j[AW-1:0]),
        .o_rdata0 (rd_e0),
        .o_rdata1 (rd_e1)
    );

    msb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_scr_ram (
        .i_clk    (i_clk),
        .i_we     (s_we),
        .i_waddr  (r_k[AW-1:0]),
        .i_wdata  (mrg_data),
        .i_raddr0 (r_i[AW-1:0]),
        .i_raddr1 (r_j[AW-1:0]),
        .o_rdata0 (rd_s0),
        .o_rdata1 (rd_s1)
    );

    // counters, pointers and config bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_desc    <= 1'b0;
            r_src     <= 1'b0;
            r_w       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_mid     <= '0;
            r_hi      <= '0;
            r_k       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_desc <= i_cfg_data;
            end
            // input collection
            if (store_en) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.load) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end
            // merge passes
            if (i_cmd.sort_init) begin
                r_w   <= WW'(1);
                r_src <= 1'b0;
            end
            if (i_cmd.merge_write) begin
                r_k <= r_k + 1'b1;
                if (take_left) begin
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (i_cmd.pass_start || i_cmd.run_next) begin
                r_i   <= lo_sel;
                r_mid <= mid_new;
                r_j   <= mid_new;
                r_hi  <= hi_new;
            end
            if (i_cmd.pass_start) begin
                r_k <= '0;
            end
            if (i_cmd.pass_end) begin
                r_w   <= r_w << 1;
                r_src <= !r_src;
            end
            // output read pointer
            if (i_cmd.out_start) begin
                r_i <= '0;
                r_k <= '0;
            end
            if (i_cmd.out_next) begin
                r_i <= r_i + 1'b1;
                r_k <= r_k + 1'b1;
            end
        end
    end

    // status to the controller
    assign o_sts.k_last    = (CW'(r_k + 1'b1) == r_count);
    assign o_sts.run_done  = (CW'(r_k + 1'b1) == r_hi);
    assign o_sts.sort_done = (r_w >= WW'(r_count));

    assign o_cfg_ready    = 1'b1;
    assign o_sorted_value = head_a;
    assign o_end_of_run   = o_sts.k_last;
    assign o_overflow     = r_dropped;

    // merged writes stay inside the run
    a_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_write |-> r_k < r_count)
        else $error("merge write beyond run length");

    // a pass ends with every element written once
    a_pass_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pass_end |=> r_k == r_count)
        else $error("merge pass did not cover the run");

    // element count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

endmodule

`default_nettype wire

// ----- rtl/core/merge_sort_buffer.sv -----
// merge_sort_buffer: loads one item per cycle while in the load state; after
// the last item a controller runs ceil(log2 n) bottom-up merge passes; each
// merged element takes a read state and a write state for the registered
// dual read of the store. The run is then emitted, one registered read per
// element, each held until the master stream accepts it.
// synchronous active-low reset clears count, overflow, order bit and state.
`default_nettype none

module merge_sort_buffer #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic signed [msb_pkg::DATA_W-1:0] i_s_tdata,  // value[63:0]
    input  wire logic                              i_s_tlast,  // last
    // master stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic signed [msb_pkg::DATA_W-1:0]      o_m_tdata,  // sorted_value[63:0]
    output logic                                   o_m_tlast,  // end_of_run
    output logic                                   o_m_tuser,  // overflow
    // config write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_data  // descending
);

    import msb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    msb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // stores, pointers and compare
    msb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_value        (i_s_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .o_sorted_value (o_m_tdata),
        .o_end_of_run   (o_m_tlast),
        .o_overflow     (o_m_tuser)
    );

endmodule

`default_nettype wire
